/* rtl/rlp3_pkg.sv */
// shared types, constants and saturation helpers for the three-pole resonant lowpass
// no dependencies
package rlp3_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int STATE_BITS  = 24;
   localparam int CUTOFF_BITS = 16;
   localparam int GAIN_BITS   = 20;
   localparam int PROD_SHIFT  = 16;
   localparam int STATE_FRAC  = STATE_BITS - 4;
   localparam int SAMPLE_FRAC = SAMPLE_BITS - 1;
   localparam int ALIGN_SHIFT = STATE_FRAC - SAMPLE_FRAC;
   // full multiplier width before the product shift
   localparam int MUL_FULL_BITS = STATE_BITS + GAIN_BITS;
   // truncated product magnitude plus sign
   localparam int PROD_BITS   = STATE_BITS + GAIN_BITS - PROD_SHIFT + 1;
   // room for a three-term sum of state and product values
   localparam int SUM_BITS    = PROD_BITS + 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 3;

   localparam logic [CUTOFF_BITS-1:0] CUTOFF_RESET = CUTOFF_BITS'(65470);
   localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = '0;

   localparam logic signed [STATE_BITS-1:0] STATE_MAX = {1'b0, {(STATE_BITS-1){1'b1}}};
   localparam logic signed [STATE_BITS-1:0] STATE_MIN = {1'b1, {(STATE_BITS-1){1'b0}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

   // register index, taken from paddr bit 2
   localparam logic REG_CUTOFF = 1'b0;
   localparam logic REG_GAIN   = 1'b1;

   localparam logic CMD_FILTER = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   typedef struct packed {
      logic [CUTOFF_BITS-1:0] cutoff;
      logic [GAIN_BITS-1:0]   gain;
   } cfg_type;

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_FB   = 9'b000000010,
      ST_BRK  = 9'b000000100,
      ST_UP1  = 9'b000001000,
      ST_D2   = 9'b000010000,
      ST_UP2  = 9'b000100000,
      ST_D3   = 9'b001000000,
      ST_UP3  = 9'b010000000,
      ST_OUT  = 9'b100000000
   } state_type;

   function automatic logic signed [STATE_BITS-1:0] sat_state(
      input logic signed [SUM_BITS-1:0] v);
      logic signed [SUM_BITS-1:0] hi;
      logic signed [SUM_BITS-1:0] lo;
      logic signed [STATE_BITS-1:0] r;
      hi = SUM_BITS'(STATE_MAX);
      lo = SUM_BITS'(STATE_MIN);
      if (v > hi) r = STATE_MAX;
      else if (v < lo) r = STATE_MIN;
      else r = v[STATE_BITS-1:0];
      return r;
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
      input logic signed [STATE_BITS-1:0] v);
      logic signed [STATE_BITS-1:0] hi;
      logic signed [STATE_BITS-1:0] lo;
      logic signed [SAMPLE_BITS-1:0] r;
      hi = STATE_BITS'(SAMPLE_MAX);
      lo = STATE_BITS'(SAMPLE_MIN);
      if (v > hi) r = SAMPLE_MAX;
      else if (v < lo) r = SAMPLE_MIN;
      else r = v[SAMPLE_BITS-1:0];
      return r;
   endfunction

endpackage

/* rtl/rlp3_csr.sv */
// configuration registers for the three-pole resonant lowpass, apb-style write and read
// depends on rlp3_pkg
module rlp3_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rlp3_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [rlp3_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [rlp3_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready,
   output rlp3_pkg::cfg_type                   cfg
);
   import rlp3_pkg::*;

   logic [CUTOFF_BITS-1:0] cutoff_ff;
   logic [CUTOFF_BITS-1:0] cutoff_in;
   logic [GAIN_BITS-1:0]   gain_ff;
   logic [GAIN_BITS-1:0]   gain_in;
   logic                   wr_en;
   logic                   reg_sel;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[2];

   always_comb begin
      cutoff_in = cutoff_ff;
      gain_in   = gain_ff;
      if (wr_en) begin
         case (reg_sel)
            REG_CUTOFF: cutoff_in = csr_pwdata[CUTOFF_BITS-1:0];
            REG_GAIN:   gain_in   = csr_pwdata[GAIN_BITS-1:0];
            default: begin
               cutoff_in = cutoff_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_CUTOFF: csr_prdata = CSR_DATA_BITS'(cutoff_ff);
         REG_GAIN:   csr_prdata = CSR_DATA_BITS'(gain_ff);
         default:    csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cutoff_ff <= CUTOFF_RESET;
         gain_ff   <= GAIN_RESET;
      end else begin
         cutoff_ff <= cutoff_in;
         gain_ff   <= gain_in;
      end
   end

   assign cfg.cutoff = cutoff_ff;
   assign cfg.gain   = gain_ff;

endmodule

/* rtl/rlp3_mul.sv */
// shared coefficient multiplier: (a * b) >> 16 truncated toward zero, registered product
// depends on rlp3_pkg
module rlp3_mul (
   input  logic                                      clock,
   input  logic signed [rlp3_pkg::STATE_BITS-1:0]    operand,
   input  logic        [rlp3_pkg::GAIN_BITS-1:0]     coeff,
   output logic signed [rlp3_pkg::PROD_BITS-1:0]     product
);
   import rlp3_pkg::*;

   logic                          neg;
   logic [STATE_BITS-1:0]         mag;
   logic [MUL_FULL_BITS-1:0]      full;
   logic [PROD_BITS-2:0]          quot;
   logic signed [PROD_BITS-1:0]   prod_in;
   logic signed [PROD_BITS-1:0]   prod_ff;

   // sign-magnitude so the shift truncates toward zero
   assign neg  = operand[STATE_BITS-1];
   assign mag  = neg ? (~operand + 1'b1) : operand;
   assign full = MUL_FULL_BITS'(mag) * MUL_FULL_BITS'(coeff);
   assign quot = full[MUL_FULL_BITS-1:PROD_SHIFT];

   always_comb begin
      if (neg) prod_in = -$signed({1'b0, quot});
      else     prod_in = $signed({1'b0, quot});
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

/* rtl/resonant_lowpass_three_pole_core.sv */
// top level of the three-pole resonant lowpass: sequencer, stage registers, result register
// depends on rlp3_pkg, rlp3_csr and rlp3_mul
//
// A filter item runs four dependent coefficient multiplies (feedback, stage one,
// stage two, stage three) through one 24x20 multiplier with a registered product; the
// feedback product feeds a saturating bracket and each stage product a saturating stage
// update, then the output state converts stage three to the sample format and offers the
// result. A clear item zeroes the stages and goes straight to the output state, which
// offers 0. req_stall is high from acceptance until the result has been loaded into the
// output register; the next item is taken while that result still waits on rsp_stall.
// Cutoff and feedback gain registers sit at byte addresses 0 and 4 and should only be
// written while the block is idle.
module resonant_lowpass_three_pole_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic                                      req_cmd,
   input  logic signed [rlp3_pkg::SAMPLE_BITS-1:0]   req_sample_in,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [rlp3_pkg::SAMPLE_BITS-1:0]   rsp_sample_out,
   input  logic                                      csr_psel,
   input  logic                                      csr_penable,
   input  logic                                      csr_pwrite,
   input  logic [rlp3_pkg::CSR_ADDR_BITS-1:0]        csr_paddr,
   input  logic [rlp3_pkg::CSR_DATA_BITS-1:0]        csr_pwdata,
   output logic [rlp3_pkg::CSR_DATA_BITS-1:0]        csr_prdata,
   output logic                                      csr_pready
);
   import rlp3_pkg::*;

   cfg_type                       cfg;
   state_type                     state_ff;
   state_type                     state_in;
   logic signed [STATE_BITS-1:0]  s1_ff, s1_in;
   logic signed [STATE_BITS-1:0]  s2_ff, s2_in;
   logic signed [STATE_BITS-1:0]  s3_ff, s3_in;
   logic signed [STATE_BITS-1:0]  x_ff, x_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                          accept;
   logic                          out_free;
   logic signed [STATE_BITS-1:0]  x_aligned;
   logic signed [STATE_BITS-1:0]  diff12;
   logic signed [STATE_BITS-1:0]  diff23;
   logic signed [STATE_BITS-1:0]  bracket;
   logic signed [STATE_BITS-1:0]  upd_base;
   logic signed [STATE_BITS-1:0]  upd;
   logic signed [STATE_BITS-1:0]  mul_operand;
   logic [GAIN_BITS-1:0]          mul_coeff;
   logic signed [PROD_BITS-1:0]   product;
   logic signed [STATE_BITS-1:0]  s3_scaled;

   rlp3_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   rlp3_mul u_mul (
      .clock   (clock),
      .operand (mul_operand),
      .coeff   (mul_coeff),
      .product (product)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid & ~req_stall;
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;

   assign x_aligned = STATE_BITS'(req_sample_in) <<< ALIGN_SHIFT;

   assign diff12  = sat_state(SUM_BITS'(s1_ff) - SUM_BITS'(s2_ff));
   assign diff23  = sat_state(SUM_BITS'(s2_ff) - SUM_BITS'(s3_ff));
   // product holds the feedback term while in the bracket step
   assign bracket = sat_state(SUM_BITS'(x_ff) - SUM_BITS'(s1_ff) + SUM_BITS'(product));

   always_comb begin
      case (state_ff)
         ST_UP1:  upd_base = s1_ff;
         ST_UP2:  upd_base = s2_ff;
         ST_UP3:  upd_base = s3_ff;
         default: upd_base = s1_ff;
      endcase
   end

   assign upd = sat_state(SUM_BITS'(upd_base) + SUM_BITS'(product));

   always_comb begin
      case (state_ff)
         ST_FB: begin
            mul_operand = diff12;
            mul_coeff   = cfg.gain;
         end
         ST_BRK: begin
            mul_operand = bracket;
            mul_coeff   = GAIN_BITS'(cfg.cutoff);
         end
         ST_D3: begin
            mul_operand = diff23;
            mul_coeff   = GAIN_BITS'(cfg.cutoff);
         end
         default: begin
            mul_operand = diff12;
            mul_coeff   = GAIN_BITS'(cfg.cutoff);
         end
      endcase
   end

   assign s3_scaled = s3_ff >>> ALIGN_SHIFT;

   always_comb begin
      state_in     = state_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      s3_in        = s3_ff;
      x_in         = x_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               x_in = x_aligned;
               if (req_cmd == CMD_CLEAR) begin
                  s1_in    = '0;
                  s2_in    = '0;
                  s3_in    = '0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_FB;
               end
            end
         end
         ST_FB:  state_in = ST_BRK;
         ST_BRK: state_in = ST_UP1;
         ST_UP1: begin
            s1_in    = upd;
            state_in = ST_D2;
         end
         ST_D2:  state_in = ST_UP2;
         ST_UP2: begin
            s2_in    = upd;
            state_in = ST_D3;
         end
         ST_D3:  state_in = ST_UP3;
         ST_UP3: begin
            s3_in    = upd;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sat_sample(s3_scaled);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         s3_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         s3_ff        <= s3_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_data_ff;

   a_onehot_state: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("sequencer state not one-hot");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("accepted item did not start work");

   a_clear_zero: assert property (@(posedge clock) disable iff (reset)
      (accept && req_cmd == CMD_CLEAR) |=> (s1_ff == '0 && s2_ff == '0 && s3_ff == '0))
      else $error("clear did not zero the stages");

   a_result_load: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && out_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item not offered");

endmodule
